// ----- design/rfp_pkg.sv -----
package rfp_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned LenW  = 16;
   localparam int unsigned FragW = 12;
   localparam int unsigned StepW = 16;
   localparam int unsigned TsW   = 32;

   localparam int unsigned ReqDataW = 24;
   localparam int unsigned RspDataW = 40;
   localparam int unsigned RspUserW = 2;

   localparam int unsigned CsrAddrW = 1;
   localparam int unsigned CsrDataW = 16;
   localparam logic [CsrAddrW-1:0] CsrMaxFragment   = 1'd0;
   localparam logic [CsrAddrW-1:0] CsrTimestampStep = 1'd1;

   localparam logic [FragW-1:0] MaxFragmentReset   = 12'd1400;
   localparam logic [StepW-1:0] TimestampStepReset = 16'd3600;

   localparam logic [4:0]    FuAType         = 5'd28;
   localparam logic [LenW:0] PrefixAndHeader = 17'd5;

   localparam int unsigned QueueDepthDefault = 4;

   // One queued NAL byte, with the two FU bytes that go ahead of it when it opens a chunk.
   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic             prefix;
      logic             first;
      logic             last;
      logic [ByteW-1:0] fu_ind;
      logic [ByteW-1:0] fu_hdr;
      logic [TsW-1:0]   stamp;
   } entry_type;

endpackage

// ----- design/h264_rtp_fua_packetizer.sv -----
// Channel   Dir  Width  Contents
// req_      in   24+1   tdata: nal_byte, payload_length; tuser: is_header
// rsp_      out  40+2   tdata: out_byte, time_stamp; tuser: packet_first, run_last;
//                       tlast: packet_last
// csr_      in   16     index 0 max_fragment, index 1 timestamp_step
//
// The front takes one NAL byte per cycle unless the queue is full and classifies it in
// the same cycle; its entry is held in the queue before it reaches the output register.
// The back sends one word per unstalled cycle: one for a plain byte, three for a byte
// opening an FU-A chunk, so the input stalls once the queue fills during chunk prefixes.
// Reset is synchronous; after it, both registers hold their defaults (1400 and 3600).
// Either side may stall at any time; the queue decouples them.
module h264_rtp_fua_packetizer #(
   parameter int unsigned QueueDepth = rfp_pkg::QueueDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [rfp_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [rfp_pkg::CsrDataW-1:0]  csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rfp_pkg::ReqDataW-1:0]  req_tdata,  // nal_byte[7:0], payload_length[23:8]
   input  logic                          req_tuser,  // is_header
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rfp_pkg::RspDataW-1:0]  rsp_tdata,  // out_byte[7:0], time_stamp[39:8]
   output logic                          rsp_tlast,
   output logic [rfp_pkg::RspUserW-1:0]  rsp_tuser   // packet_first[0], run_last[1]
);

   logic               q_full;
   logic               push;
   rfp_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   rfp_pkg::entry_type head_entry;

   rfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   rfp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   rfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- design/rfp_front.sv -----
module rfp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rfp_pkg::CsrAddrW-1:0]       csr_addr,
   input  logic [rfp_pkg::CsrDataW-1:0]       csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rfp_pkg::ReqDataW-1:0]       req_tdata,
   input  logic                               req_tuser,
   input  logic                               q_full,
   output logic                               push,
   output rfp_pkg::entry_type                 push_entry
);

   logic [rfp_pkg::FragW-1:0] max_fragment_ff, max_fragment_in;
   logic [rfp_pkg::StepW-1:0] timestamp_step_ff, timestamp_step_in;
   logic [rfp_pkg::ByteW-1:0] saved_header_ff, saved_header_in;
   logic                      fragment_mode_ff, fragment_mode_in;
   logic [rfp_pkg::LenW-1:0]  bytes_left_ff, bytes_left_in;
   logic [rfp_pkg::FragW-1:0] bytes_in_fragment_ff, bytes_in_fragment_in;
   logic                      first_fragment_ff, first_fragment_in;
   logic [rfp_pkg::TsW-1:0]   current_timestamp_ff, current_timestamp_in;

   logic                      accept;
   logic [rfp_pkg::ByteW-1:0] nal_byte;
   logic [rfp_pkg::LenW-1:0]  payload_length;
   logic [rfp_pkg::FragW-1:0] chunk;
   logic [rfp_pkg::TsW-1:0]   stamp_next;
   logic                      single;
   logic [rfp_pkg::LenW-1:0]  left_dec;
   logic [rfp_pkg::FragW:0]   fill_inc;
   logic                      starts;
   logic                      frag_last;
   logic                      end_bit;

   assign req_tready     = !q_full;
   assign accept         = req_tvalid && !q_full;
   assign nal_byte       = req_tdata[7:0];
   assign payload_length = req_tdata[23:8];

   always_comb begin
      chunk      = (max_fragment_ff == '0) ? rfp_pkg::FragW'(1) : max_fragment_ff;
      stamp_next = current_timestamp_ff + {16'd0, timestamp_step_ff};
      single     = ({1'b0, payload_length} + rfp_pkg::PrefixAndHeader) <
                   {5'd0, max_fragment_ff};
      left_dec   = bytes_left_ff - 16'd1;
      fill_inc   = {1'b0, bytes_in_fragment_ff} + 13'd1;
      starts     = (bytes_in_fragment_ff == '0);
      frag_last  = (left_dec == '0) || (fill_inc >= {1'b0, chunk});
      end_bit    = (bytes_left_ff <= {4'd0, chunk});
   end

   always_comb begin
      max_fragment_in      = max_fragment_ff;
      timestamp_step_in    = timestamp_step_ff;
      saved_header_in      = saved_header_ff;
      fragment_mode_in     = fragment_mode_ff;
      bytes_left_in        = bytes_left_ff;
      bytes_in_fragment_in = bytes_in_fragment_ff;
      first_fragment_in    = first_fragment_ff;
      current_timestamp_in = current_timestamp_ff;
      push                 = 1'b0;
      push_entry.data_byte = nal_byte;
      push_entry.prefix    = 1'b0;
      push_entry.first     = 1'b0;
      push_entry.last      = 1'b0;
      push_entry.fu_ind    = {saved_header_ff[7:5], rfp_pkg::FuAType};
      push_entry.fu_hdr    = {first_fragment_ff, end_bit, 1'b0, saved_header_ff[4:0]};
      push_entry.stamp     = current_timestamp_ff;

      if (csr_we) begin
         case (csr_addr)
            rfp_pkg::CsrMaxFragment:   max_fragment_in   = csr_wdata[rfp_pkg::FragW-1:0];
            rfp_pkg::CsrTimestampStep: timestamp_step_in = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         if (req_tuser) begin
            current_timestamp_in = stamp_next;
            saved_header_in      = nal_byte;
            bytes_left_in        = payload_length;
            bytes_in_fragment_in = '0;
            first_fragment_in    = 1'b1;
            fragment_mode_in     = !single;
            push                 = single;
            push_entry.first     = 1'b1;
            push_entry.last      = (payload_length == '0);
            push_entry.stamp     = stamp_next;
         end else if (bytes_left_ff != '0) begin
            push          = 1'b1;
            bytes_left_in = left_dec;
            if (!fragment_mode_ff) begin
               push_entry.last = (bytes_left_ff == 16'd1);
            end else begin
               push_entry.prefix = starts;
               push_entry.last   = frag_last;
               if (starts) begin
                  first_fragment_in = 1'b0;
               end
               bytes_in_fragment_in = frag_last ? '0 : fill_inc[rfp_pkg::FragW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fragment_ff      <= rfp_pkg::MaxFragmentReset;
         timestamp_step_ff    <= rfp_pkg::TimestampStepReset;
         saved_header_ff      <= '0;
         fragment_mode_ff     <= 1'b0;
         bytes_left_ff        <= '0;
         bytes_in_fragment_ff <= '0;
         first_fragment_ff    <= 1'b1;
         current_timestamp_ff <= '0;
      end else begin
         max_fragment_ff      <= max_fragment_in;
         timestamp_step_ff    <= timestamp_step_in;
         saved_header_ff      <= saved_header_in;
         fragment_mode_ff     <= fragment_mode_in;
         bytes_left_ff        <= bytes_left_in;
         bytes_in_fragment_ff <= bytes_in_fragment_in;
         first_fragment_ff    <= first_fragment_in;
         current_timestamp_ff <= current_timestamp_in;
      end
   end

endmodule

// ----- design/rfp_queue.sv -----
module rfp_queue #(
   parameter int unsigned Depth = rfp_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rfp_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output rfp_pkg::entry_type head_entry
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   rfp_pkg::entry_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count beyond depth");
`endif

endmodule

// ----- design/rfp_back.sv -----
module rfp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  rfp_pkg::entry_type            head_entry,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rfp_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                          rsp_tlast,
   output logic [rfp_pkg::RspUserW-1:0]  rsp_tuser
);

   localparam logic [1:0] PhaseInd  = 2'd0;
   localparam logic [1:0] PhaseFuh  = 2'd1;
   localparam logic [1:0] PhaseData = 2'd2;

   logic [1:0]                phase_ff, phase_in;
   logic                      valid_ff, valid_in;
   logic [rfp_pkg::ByteW-1:0] byte_ff, byte_in;
   logic                      first_ff, first_in;
   logic                      last_ff, last_in;
   logic                      run_last_ff, run_last_in;
   logic [rfp_pkg::TsW-1:0]   stamp_ff, stamp_in;
   logic                      load;

   assign load = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      phase_in    = phase_ff;
      valid_in    = valid_ff && !rsp_tready;
      byte_in     = byte_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      run_last_in = run_last_ff;
      stamp_in    = stamp_ff;
      pop         = 1'b0;
      if (load) begin
         valid_in    = 1'b1;
         stamp_in    = head_entry.stamp;
         byte_in     = head_entry.data_byte;
         first_in    = head_entry.first;
         last_in     = head_entry.last;
         run_last_in = 1'b1;
         unique case (phase_ff)
            PhaseInd: begin
               if (head_entry.prefix) begin
                  byte_in     = head_entry.fu_ind;
                  first_in    = 1'b1;
                  last_in     = 1'b0;
                  run_last_in = 1'b0;
                  phase_in    = PhaseFuh;
               end else begin
                  pop = 1'b1;
               end
            end
            PhaseFuh: begin
               byte_in     = head_entry.fu_hdr;
               first_in    = 1'b0;
               last_in     = 1'b0;
               run_last_in = 1'b0;
               phase_in    = PhaseData;
            end
            PhaseData: begin
               pop      = 1'b1;
               phase_in = PhaseInd;
            end
            default: begin
               phase_in = PhaseInd;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseInd;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      run_last_ff <= run_last_in;
      stamp_ff    <= stamp_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {stamp_ff, byte_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {run_last_ff, first_ff};

`ifndef NO_ASSERTIONS
   a_prefix_head_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PhaseInd |-> head_valid && head_entry.prefix)
      else $error("FU prefix in progress without its entry at the queue head");
   a_fuh_follows_ind: assert property (@(posedge clock) disable iff (reset)
      load && phase_ff == PhaseFuh |=> rsp_tvalid && !rsp_tuser[0] && !rsp_tlast)
      else $error("FU header word carries packet marks");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   localparam int CycleLimit = 100000;
   localparam int HoldCycles = 300;
   localparam int SettleCycles = 20;

   typedef struct {
      logic [7:0]  nal_byte;
      logic        is_header;
      logic [15:0] plen;
   } nal_item_type;

   typedef struct {
      logic [7:0]  out_byte;
      logic        pkt_first;
      logic        pkt_last;
      logic [31:0] stamp;
      logic        run_end;
   } rtp_word_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_we = 1'b0;
   logic [rfp_pkg::CsrAddrW-1:0] csr_addr = '0;
   logic [rfp_pkg::CsrDataW-1:0] csr_wdata = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [rfp_pkg::ReqDataW-1:0] req_tdata = '0;   // nal_byte[7:0], payload_length[23:8]
   logic                         req_tuser = 1'b0; // is_header
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [rfp_pkg::RspDataW-1:0] rsp_tdata;        // out_byte[7:0], time_stamp[39:8]
   logic                         rsp_tlast;
   logic [rfp_pkg::RspUserW-1:0] rsp_tuser;        // packet_first[0], run_last[1]

   h264_rtp_fua_packetizer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial forever #10 clock = ~clock;

   nal_item_type nal_bytes_todo[$];
   rtp_word_type rtp_words_due[$];
   nal_item_type on_bus;
   rtp_word_type due_word;

   // Packetizer state as the testbench tracks it.
   logic [11:0] max_frag = rfp_pkg::MaxFragmentReset;
   logic [15:0] ts_step = rfp_pkg::TimestampStepReset;
   logic [7:0]  saved_hdr = '0;
   logic        frag_mode = 1'b0;
   logic [15:0] left = '0;
   logic [11:0] in_chunk = '0;
   logic        first_chunk = 1'b1;
   logic [31:0] stamp = '0;

   bit idle_on = 1'b1;
   bit hold_armed = 1'b0;
   int hold_left = 0;
   int failures = 0;
   int bytes_sent = 0;
   int words_checked = 0;
   int settings_used = 1;
   int cycle_count = 0;

   function automatic void push_word(logic [7:0] b, logic f, logic l, logic r);
      rtp_word_type w;
      w.out_byte = b;
      w.pkt_first = f;
      w.pkt_last = l;
      w.stamp = stamp;
      w.run_end = r;
      rtp_words_due.push_back(w);
   endfunction

   task automatic packetize(input nal_item_type it);
      logic [11:0] chunk;
      logic        ends;
      chunk = (max_frag == '0) ? 12'd1 : max_frag;
      if (it.is_header) begin
         stamp = stamp + {16'd0, ts_step};
         saved_hdr = it.nal_byte;
         left = it.plen;
         in_chunk = '0;
         first_chunk = 1'b1;
         if ({1'b0, it.plen} + rfp_pkg::PrefixAndHeader < {5'd0, max_frag}) begin
            frag_mode = 1'b0;
            push_word(it.nal_byte, 1'b1, it.plen == '0, 1'b1);
         end else begin
            frag_mode = 1'b1;
         end
      end else if (left != '0) begin
         if (!frag_mode) begin
            push_word(it.nal_byte, 1'b0, left == 16'd1, 1'b1);
            left = left - 16'd1;
         end else begin
            // A byte that opens a chunk is preceded by the FU indicator and FU header.
            if (in_chunk == '0) begin
               push_word({saved_hdr[7:5], rfp_pkg::FuAType}, 1'b1, 1'b0, 1'b0);
               push_word({first_chunk, left <= {4'd0, chunk}, 1'b0, saved_hdr[4:0]},
                         1'b0, 1'b0, 1'b0);
               first_chunk = 1'b0;
            end
            in_chunk = in_chunk + 12'd1;
            left = left - 16'd1;
            ends = (left == '0) || (in_chunk >= chunk);
            push_word(it.nal_byte, 1'b0, ends, 1'b1);
            if (ends) in_chunk = '0;
         end
      end
   endtask

   function automatic void add_item(int b, bit hdr, int plen);
      nal_item_type it;
      it.nal_byte = b[7:0];
      it.is_header = hdr;
      it.plen = plen[15:0];
      nal_bytes_todo.push_back(it);
   endfunction

   // Mostly complete NAL units; some truncated by an early header, some stray bytes.
   task automatic add_random_nals(input int count);
      int n, r, plen, nbytes, ch, span;
      n = 0;
      ch = (max_frag == '0) ? 1 : int'(max_frag);
      span = (3 * ch > 20) ? 20 : 3 * ch;
      while (n < count) begin
         r = $urandom_range(99);
         if (r < 8) begin
            add_item($urandom_range(255), 1'b0, $urandom_range(65535));
         end else begin
            case ($urandom_range(3))
               0: plen = $urandom_range(3);
               1: plen = (ch > 6 && ch < 40) ? ch - 6 + $urandom_range(2) : $urandom_range(8);
               default: plen = $urandom_range(span);
            endcase
            nbytes = plen;
            if (r < 16) begin
               plen = $urandom_range(65535);
               nbytes = $urandom_range(3);
            end else if (r < 22 && plen > 1) begin
               nbytes = $urandom_range(plen - 1);
            end
            add_item($urandom_range(255), 1'b1, plen);
            for (int i = 0; i < nbytes; i++)
               add_item($urandom_range(255), 1'b0, $urandom_range(65535));
            n = n + 1 + nbytes;
         end
      end
   endtask

   task automatic drain();
      while (nal_bytes_todo.size() != 0 || req_tvalid || rtp_words_due.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rfp_pkg::CsrAddrW-1:0] idx,
                            input logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == rfp_pkg::CsrMaxFragment) max_frag = value[11:0];
      else ts_step = value;
   endtask

   task automatic set_regs(input logic [11:0] mf, input logic [15:0] step);
      write_reg(rfp_pkg::CsrMaxFragment, {4'd0, mf});
      write_reg(rfp_pkg::CsrTimestampStep, step);
      settings_used++;
   endtask

   // Driver: presents queued NAL bytes, predicting each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            packetize(on_bus);
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (nal_bytes_todo.size() != 0 && !(idle_on && $urandom_range(99) < 22)) begin
               on_bus = nal_bytes_todo.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {on_bus.plen, on_bus.nal_byte};
               req_tuser <= on_bus.is_header;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted word against the oldest expected one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rtp_words_due.size() == 0) begin
               $error("unexpected word: out_byte %h", rsp_tdata[7:0]);
               failures++;
            end else begin
               due_word = rtp_words_due.pop_front();
               words_checked++;
               if (rsp_tdata[7:0] !== due_word.out_byte) begin
                  $error("out_byte: expected %h, got %h", due_word.out_byte, rsp_tdata[7:0]);
                  failures++;
               end
               if (rsp_tuser[0] !== due_word.pkt_first) begin
                  $error("packet_first: expected %b, got %b", due_word.pkt_first, rsp_tuser[0]);
                  failures++;
               end
               if (rsp_tlast !== due_word.pkt_last) begin
                  $error("packet_last: expected %b, got %b", due_word.pkt_last, rsp_tlast);
                  failures++;
               end
               if (rsp_tdata[39:8] !== due_word.stamp) begin
                  $error("time_stamp: expected %h, got %h", due_word.stamp, rsp_tdata[39:8]);
                  failures++;
               end
               if (rsp_tuser[1] !== due_word.run_end) begin
                  $error("run_last: expected %b, got %b", due_word.run_end, rsp_tuser[1]);
                  failures++;
               end
            end
         end
         // A long hold-off lets the internal queue fill and back-pressure the input.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_armed && rsp_tvalid) begin
            hold_armed = 1'b0;
            hold_left = HoldCycles;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(99) < 22);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default registers: empty single NAL, stray byte, short NAL, longest length
      // cut short, and both sides of the single-packet threshold.
      add_item(8'hFF, 1'b1, 0);
      add_item(8'h00, 1'b0, 16'hFFFF);
      add_item(8'h65, 1'b1, 2);
      add_item(8'hAA, 1'b0, 0);
      add_item(8'h55, 1'b0, 0);
      add_item(8'h7C, 1'b1, 16'hFFFF);
      add_item(8'hFF, 1'b0, 0);
      add_item(8'h00, 1'b0, 0);
      add_item(8'h81, 1'b0, 0);
      add_item(8'hE1, 1'b1, 1394);
      add_item(8'h12, 1'b0, 0);
      add_item(8'h41, 1'b1, 1395);
      add_item(8'h34, 1'b0, 0);
      add_item(8'h5F, 1'b1, 0);
      drain();

      // Zero chunk size acts as one: an empty NAL yields nothing, every byte opens a chunk.
      set_regs(12'd0, 16'hFFFF);
      add_item(8'h80, 1'b1, 0);
      add_item(8'h3C, 1'b0, 0);
      add_item(8'h9A, 1'b1, 3);
      add_item(8'h01, 1'b0, 0);
      add_item(8'hFE, 1'b0, 0);
      add_item(8'h7F, 1'b0, 0);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         idle_on = 1'b1;
         case (ph)
            0: set_regs(12'd1, 16'd1);
            1: set_regs(12'($urandom_range(6, 12)), 16'($urandom_range(65535)));
            2: set_regs(12'($urandom_range(13, 40)), 16'($urandom_range(65535)));
            3: set_regs(12'd4095, 16'd0);
            default: set_regs(12'd5, 16'hFFFF);
         endcase
         if (ph == 1) hold_armed = 1'b1;
         if (ph == 2) idle_on = 1'b0;
         add_random_nals(46);
         drain();
      end

      $display("Sent %0d NAL bytes under %0d register settings; %0d RTP words checked.",
               bytes_sent, settings_used, words_checked);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
